FILE: sv/gcq_pkg.sv
// Shared types, constants and helpers for the graph connectivity query block.
// No dependencies; gcq_pick and graph_connectivity_query import this package.
package gcq_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int IDX_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int VTX_W  = 7;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 2;
  localparam int CMP_W  = (VTX_W > CNT_W) ? VTX_W : CNT_W;

  typedef logic [MAX_VERTICES-1:0] row_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAME  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_A,
    S_ADD_B,
    S_POP,
    S_ROW,
    S_SCAN,
    S_PUSH
  } state_t;

  // Lowest pending vertex and what is left after taking it.
  typedef struct packed {
    logic             any;
    logic [IDX_W-1:0] idx;
    row_t             rest;
  } pick_t;

endpackage

FILE: sv/gcq_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module gcq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/gcq_pick.sv
// Picks the lowest set bit of the pending neighbor word for the next push.
// Depends on gcq_pkg.
module gcq_pick (
  input  gcq_pkg::row_t  pend,
  output gcq_pkg::pick_t res
);
  import gcq_pkg::*;

  row_t             lsb;
  logic [IDX_W-1:0] idx;

  // isolate lowest one, then encode it
  assign lsb = pend & (~pend + row_t'(1));

  always_comb begin
    idx = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (lsb[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
  end

  assign res.any  = |pend;
  assign res.idx  = idx;
  assign res.rest = pend & ~lsb;

endmodule

FILE: sv/graph_connectivity_query.sv
// Top level of the graph connectivity query block: request sequencer and search.
// Depends on gcq_pkg, gcq_ram (adjacency rows, search stack) and gcq_pick.
//
// Requests: drive in_req_type, in_first_vertex, in_second_vertex and raise start;
//   the beat is taken at an edge where start is high and busy is low. busy stays
//   high until the request is finished; one request is in flight at a time and the
//   next can be taken in the cycle of the previous result beat.
// Results: one beat per request, out_valid high for one cycle with out_connected
//   and out_status. The receiver cannot stall.
// Configuration: cfg_num_vertices is written on cfg_valid (cfg_ready is always
//   high). Write it only while no request is in flight.
// Sequence from accept to result beat
//   Rejected add or query, unused type: answered from S_IDLE. Add edge: S_ADD_A, then
//   S_ADD_B when the two vertices differ (read-modify-write of each row through the
//   single read port). Clear: S_CLEAR, one adjacency row zeroed per cycle.
//   Query: per popped vertex a stack read, a row read, a scan, a push of each new
//   neighbor and one more step that finds none left; an empty stack ends the search.
// Reset: rst_n is synchronous, active low. The block then sweeps the adjacency RAM
//   to zero with busy high, and config writes are taken during the sweep.
//   num_vertices resets to 64.
module graph_connectivity_query (
  input  logic                         clk,
  input  logic                         rst_n,
  // request channel
  input  logic                         start,
  output logic                         busy,
  input  logic [gcq_pkg::REQ_W-1:0]    in_req_type,
  input  logic [gcq_pkg::VTX_W-1:0]    in_first_vertex,
  input  logic [gcq_pkg::VTX_W-1:0]    in_second_vertex,
  // result channel
  output logic                         out_valid,
  output logic                         out_connected,
  output logic [gcq_pkg::STAT_W-1:0]   out_status,
  // configuration channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [gcq_pkg::VTX_W-1:0]    cfg_num_vertices
);
  import gcq_pkg::*;

  // ---------------------------------------------------------------- registers
  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    a_idx_r, a_idx_nxt;
  logic [IDX_W-1:0]    b_idx_r, b_idx_nxt;
  logic [VTX_W-1:0]    num_vertices_r, num_vertices_nxt;
  row_t                visited_r, visited_nxt;
  row_t                pend_r, pend_nxt;
  logic [CNT_W-1:0]    sp_r, sp_nxt;
  logic [IDX_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic                clr_req_r, clr_req_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_connected_r, out_connected_nxt;
  logic [STAT_W-1:0]   out_status_r, out_status_nxt;

  // ---------------------------------------------------------------- memories
  logic             adj_we;
  logic [IDX_W-1:0] adj_waddr, adj_raddr;
  row_t             adj_wdata, adj_rdata;
  logic             stk_we;
  logic [IDX_W-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata;

  gcq_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  // search stack holds vertex index (id minus one)
  gcq_ram #(.WIDTH(IDX_W), .DEPTH(MAX_VERTICES)) u_stk (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  pick_t pick;

  gcq_pick u_pick (
    .pend (pend_r),
    .res  (pick)
  );

  // ---------------------------------------------------------------- ranges
  // active count = min(num_vertices, MAX_VERTICES)
  logic [CMP_W-1:0] num_ext, n_act, a_ext, b_ext, a_m1, b_m1;
  logic             a_ok, b_ok;
  logic [IDX_W-1:0] a_idx, b_idx;
  row_t             act_mask;

  assign num_ext = CMP_W'(num_vertices_r);
  assign n_act   = (num_ext < CMP_W'(MAX_VERTICES)) ? num_ext : CMP_W'(MAX_VERTICES);
  assign a_ext   = CMP_W'(in_first_vertex);
  assign b_ext   = CMP_W'(in_second_vertex);
  assign a_ok    = (a_ext != '0) && (a_ext <= n_act);
  assign b_ok    = (b_ext != '0) && (b_ext <= n_act);
  assign a_m1    = a_ext - CMP_W'(1);
  assign b_m1    = b_ext - CMP_W'(1);
  assign a_idx   = a_m1[IDX_W-1:0];
  assign b_idx   = b_m1[IDX_W-1:0];

  // vertices above the active count are never followed
  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      act_mask[i] = CMP_W'(i) < n_act;
    end
  end

  // ---------------------------------------------------------------- state reg
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_cnt_r      <= '0;
      clr_req_r      <= 1'b0;
      num_vertices_r <= VTX_W'(64);
      visited_r      <= '0;
      sp_r           <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      clr_cnt_r      <= clr_cnt_nxt;
      clr_req_r      <= clr_req_nxt;
      num_vertices_r <= num_vertices_nxt;
      visited_r      <= visited_nxt;
      sp_r           <= sp_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    a_idx_r         <= a_idx_nxt;
    b_idx_r         <= b_idx_nxt;
    pend_r          <= pend_nxt;
    out_connected_r <= out_connected_nxt;
    out_status_r    <= out_status_nxt;
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt         = state_r;
    a_idx_nxt         = a_idx_r;
    b_idx_nxt         = b_idx_r;
    visited_nxt       = visited_r;
    pend_nxt          = pend_r;
    sp_nxt            = sp_r;
    clr_cnt_nxt       = clr_cnt_r;
    clr_req_nxt       = clr_req_r;
    out_valid_nxt     = 1'b0;
    out_connected_nxt = out_connected_r;
    out_status_nxt    = out_status_r;
    num_vertices_nxt  = cfg_valid ? cfg_num_vertices : num_vertices_r;

    adj_we    = 1'b0;
    adj_waddr = a_idx_r;
    adj_wdata = '0;
    adj_raddr = a_idx;
    stk_we    = 1'b0;
    stk_waddr = sp_r[IDX_W-1:0];
    stk_wdata = a_idx;
    stk_raddr = IDX_W'(sp_r - CNT_W'(1));

    case (state_r)
      S_CLEAR: begin
        adj_we    = 1'b1;
        adj_waddr = clr_cnt_r;
        adj_wdata = '0;
        if (clr_cnt_r == IDX_W'(MAX_VERTICES - 1)) begin
          state_nxt   = S_IDLE;
          clr_req_nxt = 1'b0;
          if (clr_req_r) begin
            out_valid_nxt     = 1'b1;
            out_connected_nxt = 1'b0;
            out_status_nxt    = ST_OK;
          end
        end else begin
          clr_cnt_nxt = clr_cnt_r + IDX_W'(1);
        end
      end

      S_IDLE: begin
        // adj_raddr already points at the first vertex's row
        a_idx_nxt = a_idx;
        b_idx_nxt = b_idx;
        if (start) begin
          case (req_t'(in_req_type))
            REQ_CLEAR: begin
              visited_nxt = '0;
              clr_cnt_nxt = '0;
              clr_req_nxt = 1'b1;
              state_nxt   = S_CLEAR;
            end
            REQ_ADD: begin
              if (!(a_ok && b_ok)) begin
                out_valid_nxt     = 1'b1;
                out_connected_nxt = 1'b0;
                out_status_nxt    = ST_RANGE;
              end else begin
                state_nxt = S_ADD_A;
              end
            end
            REQ_QUERY: begin
              if (!(a_ok && b_ok)) begin
                out_valid_nxt     = 1'b1;
                out_connected_nxt = 1'b0;
                out_status_nxt    = ST_RANGE;
              end else if (a_idx == b_idx) begin
                out_valid_nxt     = 1'b1;
                out_connected_nxt = 1'b0;
                out_status_nxt    = ST_SAME;
              end else begin
                // seed: mark and push the start vertex
                visited_nxt = row_t'(1) << a_idx;
                stk_we      = 1'b1;
                stk_waddr   = '0;
                stk_wdata   = a_idx;
                sp_nxt      = CNT_W'(1);
                state_nxt   = S_POP;
              end
            end
            default: begin
              out_valid_nxt     = 1'b1;
              out_connected_nxt = 1'b0;
              out_status_nxt    = ST_OK;
            end
          endcase
        end
      end

      S_ADD_A: begin
        adj_we    = 1'b1;
        adj_waddr = a_idx_r;
        adj_wdata = adj_rdata | (row_t'(1) << b_idx_r);
        adj_raddr = b_idx_r;
        if (a_idx_r == b_idx_r) begin
          // self edge: one row, one bit
          state_nxt         = S_IDLE;
          out_valid_nxt     = 1'b1;
          out_connected_nxt = 1'b0;
          out_status_nxt    = ST_OK;
        end else begin
          state_nxt = S_ADD_B;
        end
      end

      S_ADD_B: begin
        adj_we            = 1'b1;
        adj_waddr         = b_idx_r;
        adj_wdata         = adj_rdata | (row_t'(1) << a_idx_r);
        state_nxt         = S_IDLE;
        out_valid_nxt     = 1'b1;
        out_connected_nxt = 1'b0;
        out_status_nxt    = ST_OK;
      end

      S_POP: begin
        if (sp_r == '0) begin
          state_nxt         = S_IDLE;
          out_valid_nxt     = 1'b1;
          out_connected_nxt = visited_r[b_idx_r];
          out_status_nxt    = ST_OK;
        end else begin
          sp_nxt    = sp_r - CNT_W'(1);
          state_nxt = S_ROW;
        end
      end

      S_ROW: begin
        adj_raddr = stk_rdata;
        state_nxt = S_SCAN;
      end

      S_SCAN: begin
        pend_nxt    = adj_rdata & act_mask & ~visited_r;
        visited_nxt = visited_r | (adj_rdata & act_mask);
        state_nxt   = S_PUSH;
      end

      S_PUSH: begin
        if (!pick.any) begin
          state_nxt = S_POP;
        end else begin
          stk_we    = 1'b1;
          stk_waddr = sp_r[IDX_W-1:0];
          stk_wdata = pick.idx;
          sp_nxt    = sp_r + CNT_W'(1);
          pend_nxt  = pick.rest;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy          = (state_r != S_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_connected = out_connected_r;
  assign out_status    = out_status_r;

  // ---------------------------------------------------------------- checks
  a_sweep_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("block not busy after reset");

  a_conn_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_connected_r) |-> (out_status_r == ST_OK))
    else $error("connected reported with error status");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= CNT_W'(MAX_VERTICES))
    else $error("search stack overflow");

  a_push_visited: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH && pick.any) |=> visited_r[$past(pick.idx)])
    else $error("pushed vertex not marked visited");

  a_adj_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    adj_we |-> (state_r == S_CLEAR || state_r == S_ADD_A || state_r == S_ADD_B))
    else $error("adjacency write outside clear or add");

endmodule
